### src/nfpa_pkg.sv
// Shared types, constants and a helper function of the next-fit page allocator.
package nfpa_pkg;

    // Default sizes of the map and the run buffer.
    localparam int PAGES_DEF   = 4096;
    localparam int MAX_RUN_DEF = 32;

    // Map word geometry: one memory word holds this many page bits.
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);

    // Fixed field widths of the request and result.
    localparam int KIND_W  = 2;
    localparam int PAGE_W  = 12;
    localparam int RUN_W   = 6;
    localparam int TOTAL_W = 13;

    // Page count after reset.
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        K_FIND_ONE  = 2'd0,
        K_FIND_RUN  = 2'd1,
        K_MARK_USED = 2'd2,
        K_MARK_FREE = 2'd3
    } t_kind;

    // One request.
    typedef struct packed {
        t_kind              kind;
        logic [PAGE_W-1:0]  page_index;
        logic [RUN_W-1:0]   run_length;
    } t_req;

    // One result.
    typedef struct packed {
        logic [PAGE_W-1:0]  found_page;
        logic               success;
        logic               last;
    } t_res;

    // Index of the lowest set bit of a map word; zero when none is set.
    function automatic logic [BIT_W-1:0] ffs_word(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### src/nfpa_rem.sv
// Bit-serial restoring remainder unit that folds the search pointer into range.
module nfpa_rem
    import nfpa_pkg::*;
#(
    parameter int PAGES = PAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [$clog2(PAGES)-1:0]     i_num,
    input  logic [$clog2(PAGES+1)-1:0]   i_den,
    output logic                         o_done,
    output logic [$clog2(PAGES)-1:0]     o_rem
);

    localparam int IDX_W = $clog2(PAGES);
    localparam int CNT_W = $clog2(PAGES + 1);
    localparam int STP_W = $clog2(IDX_W + 1);

    logic             r_run;
    logic [STP_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_num;
    logic [CNT_W-1:0] r_den;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W:0]   trial;

    // Bring down the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        trial = {r_rem, r_num[IDX_W-1]};
    end

    // One quotient bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_go) begin
            r_run <= 1'b1;
            r_cnt <= STP_W'(IDX_W);
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_num <= r_num << 1;
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= CNT_W'(trial - {1'b0, r_den});
                end else begin
                    r_rem <= CNT_W'(trial);
                end
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_done = r_run && (r_cnt == '0);
    assign o_rem  = IDX_W'(r_rem);

endmodule

### src/next_fit_page_bitmap_allocator_core.sv
// Next-fit page allocator: used-page bitmap in a word RAM, search sequencer, run buffer.
// A mark writes its word back and gives its acknowledgement; a find reads one 32-page word
// per cycle while it finds no page to take, up to ceil(total/32)+1 words visited for a single page.
// A run collects its pages into the run buffer and then streams them out; any request
// first has the pointer folded into range when the pointer lies at or beyond the total.
// After reset a clearing pass writes (PAGES+31)/32 words with busy high; results cannot stall.
module next_fit_page_bitmap_allocator_core
    import nfpa_pkg::*;
#(
    parameter int PAGES   = PAGES_DEF,
    parameter int MAX_RUN = MAX_RUN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    input  logic               i_cfg_we,
    input  logic [TOTAL_W-1:0] i_cfg_wdata,
    output logic               o_strobe,
    output t_res               o_res
);

    localparam int IDX_W  = $clog2(PAGES);
    localparam int CNT_W  = $clog2(PAGES + 1);
    localparam int NWORDS = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PG_W   = WA_W + BIT_W;
    localparam int RC_W   = $clog2(MAX_RUN + 1);
    localparam int RB_W   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_READ  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_MARK  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    // Sequencer state.
    t_state             r_state, n_state;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    t_req               r_req, n_req;
    logic [RC_W-1:0]    r_want, n_want;
    logic [WA_W-1:0]    r_w, n_w;
    logic               r_first, n_first;
    logic               r_wrapped, n_wrapped;
    logic               r_loaded, n_loaded;
    logic [WORD_W-1:0]  r_mask, n_mask;
    logic [RC_W-1:0]    r_n, n_n;
    logic [RC_W-1:0]    r_e, n_e;
    logic               r_bvalid, n_bvalid;
    logic [RC_W-1:0]    r_bidx, n_bidx;
    logic               r_strobe, n_strobe;
    t_res               r_res, n_res;

    // Memories and their ports.
    logic [WORD_W-1:0]  r_map_mem [NWORDS];
    logic [WORD_W-1:0]  r_rdata;
    logic               map_re, map_we;
    logic [WA_W-1:0]    map_ra, map_wa;
    logic [WORD_W-1:0]  map_wd;
    logic [PAGE_W-1:0]  r_buf_mem [MAX_RUN];
    logic [PAGE_W-1:0]  r_bdata;
    logic               buf_we, buf_re;
    logic [RB_W-1:0]    buf_wa;

    // Derived search values.
    logic [CNT_W-1:0]   eff_total;
    logic [IDX_W-1:0]   tm1;
    logic [PG_W-1:0]    tm1_pg, ptr_pg, ipidx_pg, rpidx_pg;
    logic [WA_W-1:0]    last_w, start_w, next_w;
    logic [BIT_W-1:0]   last_b, start_b, b_sel;
    logic               wrap_visit;
    logic [WORD_W-1:0]  win, cur, cur_clr, mark_bit;
    logic [PG_W-1:0]    page_pg;
    logic [IDX_W-1:0]   page, next_ptr;
    logic [CNT_W-1:0]   page_inc;
    logic               rem_go, rem_done;
    logic [IDX_W-1:0]   rem_val;
    t_req               d_req;
    logic               dispatch;

    // Pointer folding unit.
    nfpa_rem #(
        .PAGES (PAGES)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (rem_go),
        .i_num   (r_ptr),
        .i_den   (eff_total),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    // Page count clamped to the range the map supports.
    always_comb begin
        if (r_total == '0) begin
            eff_total = CNT_W'(1);
        end else if (32'(r_total) > PAGES) begin
            eff_total = CNT_W'(PAGES);
        end else begin
            eff_total = CNT_W'(r_total);
        end
    end

    // Word and bit positions of the last page and of the search start.
    always_comb begin
        d_req    = (r_state == S_MOD) ? r_req : i_req;
        tm1      = IDX_W'(eff_total - CNT_W'(1));
        tm1_pg   = PG_W'(tm1);
        ptr_pg   = PG_W'(r_ptr);
        ipidx_pg = PG_W'(d_req.page_index);
        rpidx_pg = PG_W'(r_req.page_index);
        last_w   = tm1_pg[PG_W-1:BIT_W];
        last_b   = tm1_pg[BIT_W-1:0];
        start_w  = ptr_pg[PG_W-1:BIT_W];
        start_b  = ptr_pg[BIT_W-1:0];
        next_w   = (r_w == last_w) ? '0 : WA_W'(r_w + 1'b1);
        mark_bit = WORD_W'(1) << rpidx_pg[BIT_W-1:0];
    end

    // The start word is seen twice: its upper part first, its lower part after the wrap.
    assign wrap_visit = r_wrapped && (r_w == start_w);

    // Pages of the current word that this visit may take.
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            win[b] = 1'b1;
            if ((r_w == last_w) && (BIT_W'(b) > last_b)) begin
                win[b] = 1'b0;
            end
            if (r_first && (BIT_W'(b) < start_b)) begin
                win[b] = 1'b0;
            end
            if (wrap_visit && (BIT_W'(b) >= start_b)) begin
                win[b] = 1'b0;
            end
        end
    end

    // Lowest free page still pending in the current word.
    always_comb begin
        cur      = r_loaded ? r_mask : (~r_rdata & win);
        b_sel    = ffs_word(cur);
        cur_clr  = cur & ~(WORD_W'(1) << b_sel);
        page_pg  = {r_w, b_sel};
        page     = IDX_W'(page_pg);
        page_inc = CNT_W'(page) + CNT_W'(1);
        next_ptr = (page_inc == eff_total) ? '0 : IDX_W'(page_inc);
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state   = r_state;
        n_total   = i_cfg_we ? i_cfg_wdata : r_total;
        n_ptr     = r_ptr;
        n_req     = r_req;
        n_want    = r_want;
        n_w       = r_w;
        n_first   = r_first;
        n_wrapped = r_wrapped;
        n_loaded  = r_loaded;
        n_mask    = r_mask;
        n_n       = r_n;
        n_e       = r_e;
        n_bvalid  = 1'b0;
        n_bidx    = r_bidx;
        n_strobe  = 1'b0;
        n_res     = r_res;
        map_re    = 1'b0;
        map_ra    = r_w;
        map_we    = 1'b0;
        map_wa    = r_w;
        map_wd    = '0;
        buf_we    = 1'b0;
        buf_wa    = r_n[RB_W-1:0];
        buf_re    = 1'b0;
        rem_go    = 1'b0;
        dispatch  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // Zero one map word per cycle.
                map_we = 1'b1;
                if (r_w == WA_W'(NWORDS - 1)) begin
                    n_w     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_w = WA_W'(r_w + 1'b1);
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_req  = i_req;
                    n_want = RC_W'(i_req.run_length);
                    if (32'(r_ptr) >= 32'(eff_total)) begin
                        // Every request first folds a pointer left beyond the total.
                        rem_go  = 1'b1;
                        n_state = S_MOD;
                    end else begin
                        dispatch = 1'b1;
                    end
                end
            end

            S_MOD: begin
                // The folded pointer stays even if the search then fails.
                if (rem_done) begin
                    n_ptr    = rem_val;
                    dispatch = 1'b1;
                end
            end

            S_READ: begin
                map_re  = 1'b1;
                map_ra  = start_w;
                n_w     = start_w;
                n_state = S_SCAN;
            end

            S_SCAN: begin
                if (cur == '0) begin
                    if (wrap_visit) begin
                        // Whole map searched without success.
                        n_strobe         = 1'b1;
                        n_res.found_page = '0;
                        n_res.success    = 1'b0;
                        n_res.last       = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        map_re   = 1'b1;
                        map_ra   = next_w;
                        n_w      = next_w;
                        n_first  = 1'b0;
                        n_loaded = 1'b0;
                        if (r_w == last_w) begin
                            n_wrapped = 1'b1;
                        end
                    end
                end else if (r_req.kind == K_FIND_ONE) begin
                    n_ptr            = page;
                    n_strobe         = 1'b1;
                    n_res.found_page = PAGE_W'(page);
                    n_res.success    = 1'b1;
                    n_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    // Collect this page into the run buffer.
                    buf_we = 1'b1;
                    n_n    = RC_W'(r_n + 1'b1);
                    if (RC_W'(r_n + 1'b1) == r_want) begin
                        n_ptr   = next_ptr;
                        n_e     = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_mask   = cur_clr;
                        n_loaded = 1'b1;
                    end
                end
            end

            S_MARK: begin
                // Write the word back with one bit changed.
                map_we = 1'b1;
                map_wa = r_w;
                if (r_req.kind == K_MARK_USED) begin
                    map_wd = r_rdata | mark_bit;
                end else begin
                    map_wd = r_rdata & ~mark_bit;
                end
                n_strobe         = 1'b1;
                n_res.found_page = '0;
                n_res.success    = 1'b1;
                n_res.last       = 1'b1;
                n_state          = S_IDLE;
            end

            S_EMIT: begin
                // Read one buffer entry per cycle and present the one read before.
                if (r_e != r_want) begin
                    buf_re   = 1'b1;
                    n_e      = RC_W'(r_e + 1'b1);
                    n_bvalid = 1'b1;
                    n_bidx   = r_e;
                end
                if (r_bvalid) begin
                    n_strobe         = 1'b1;
                    n_res.found_page = r_bdata;
                    n_res.success    = 1'b1;
                    n_res.last       = (RC_W'(r_bidx + 1'b1) == r_want);
                    if (RC_W'(r_bidx + 1'b1) == r_want) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase

        // Serve the request once the pointer is known to be in range.
        if (dispatch) begin
            unique case (d_req.kind) inside
                K_MARK_USED, K_MARK_FREE: begin
                    if (32'(d_req.page_index) >= 32'(eff_total)) begin
                        n_strobe         = 1'b1;
                        n_res.found_page = '0;
                        n_res.success    = 1'b0;
                        n_res.last       = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        map_re  = 1'b1;
                        map_ra  = ipidx_pg[PG_W-1:BIT_W];
                        n_w     = ipidx_pg[PG_W-1:BIT_W];
                        n_state = S_MARK;
                    end
                end
                K_FIND_ONE, K_FIND_RUN: begin
                    if ((d_req.kind == K_FIND_RUN) &&
                        ((d_req.run_length == '0) ||
                         (32'(d_req.run_length) > MAX_RUN))) begin
                        n_strobe         = 1'b1;
                        n_res.found_page = '0;
                        n_res.success    = 1'b0;
                        n_res.last       = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_first   = 1'b1;
                        n_wrapped = 1'b0;
                        n_loaded  = 1'b0;
                        n_n       = '0;
                        n_state   = S_READ;
                    end
                end
            endcase
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_total  <= TOTAL_RESET;
            r_ptr    <= '0;
            r_w      <= '0;
            r_bvalid <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_ptr    <= n_ptr;
            r_w      <= n_w;
            r_bvalid <= n_bvalid;
            r_strobe <= n_strobe;
        end
        r_req     <= n_req;
        r_want    <= n_want;
        r_first   <= n_first;
        r_wrapped <= n_wrapped;
        r_loaded  <= n_loaded;
        r_mask    <= n_mask;
        r_n       <= n_n;
        r_e       <= n_e;
        r_bidx    <= n_bidx;
        r_res     <= n_res;
    end

    // Used-page bitmap, one read and one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_rdata <= r_map_mem[map_ra];
        end
    end

    // Run buffer, written during the search and read while streaming out.
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf_mem[buf_wa] <= PAGE_W'(page);
        end
        if (buf_re) begin
            r_bdata <= r_buf_mem[r_e[RB_W-1:0]];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    // A run streams out without gaps until its last page.
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |=> o_strobe)
        else $error("run result stream broke before its last page");

    // No result is produced while the map is being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_strobe)
        else $error("result strobed during the clearing pass");

    // A failed result carries page zero.
    a_fail_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.success |-> (o_res.found_page == '0) && o_res.last)
        else $error("failed result with nonzero page or without last");

    // Results that are not last come only from streaming a run.
    a_nonlast_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |-> $past(r_state == S_EMIT))
        else $error("non-final result outside run streaming");
`endif

endmodule

### tb/sv/nfpa_checker.sv
// Checker that mirrors the page allocator and compares every strobed result with its prediction.
`timescale 1ns / 1ps
module nfpa_checker
    import nfpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  t_req               i_req,
    input  logic               i_cfg_we,
    input  logic [TOTAL_W-1:0] i_cfg_wdata,
    input  logic               i_strobe,
    input  t_res               i_res,
    output int                 o_fail_count,
    output int                 o_pending
);

    // Mirror of the allocator state.
    logic               page_used [PAGES_DEF];
    logic [PAGE_W-1:0]  next_ptr;
    logic [TOTAL_W-1:0] total_pages;

    // Results still owed by the block, oldest first.
    t_res               due_results [$];
    t_res               head;
    int                 fails = 0;

    // The page count clamped to the range the block supports.
    function automatic int unsigned effective_total();
        int unsigned t;
        t = total_pages;
        if (t < 1) begin
            t = 1;
        end
        if (t > PAGES_DEF) begin
            t = PAGES_DEF;
        end
        return t;
    endfunction

    function automatic t_res pack_result(input int unsigned page, input logic ok,
                                         input logic fin);
        t_res r;
        r.found_page = PAGE_W'(page);
        r.success    = ok;
        r.last       = fin;
        return r;
    endfunction

    // Applies one request to the mirror and queues the results it owes.
    task automatic search_and_mark(input t_req req);
        int unsigned tot;
        int unsigned p;
        int unsigned i;
        int unsigned want;
        logic        found;
        int unsigned run_pages [$];
        tot = effective_total();
        p = next_ptr % tot;
        next_ptr = PAGE_W'(p);
        case (req.kind)
            K_FIND_ONE: begin
                // Scan at most one full pass for a free page.
                found = 1'b0;
                i = 0;
                while (i < tot && !found) begin
                    if (!page_used[p]) begin
                        found = 1'b1;
                    end else begin
                        p = (p + 1 == tot) ? 0 : p + 1;
                        i++;
                    end
                end
                if (found) begin
                    next_ptr = PAGE_W'(p);
                    due_results.push_back(pack_result(p, 1'b1, 1'b1));
                end else begin
                    due_results.push_back(pack_result(0, 1'b0, 1'b1));
                end
            end
            K_FIND_RUN: begin
                // Gather free pages in search order within one pass.
                want = req.run_length;
                if (want >= 1 && want <= MAX_RUN_DEF) begin
                    for (i = 0; i < tot && run_pages.size() < want; i++) begin
                        if (!page_used[p]) begin
                            run_pages.push_back(p);
                        end
                        p = (p + 1 == tot) ? 0 : p + 1;
                    end
                end
                if (want == 0 || run_pages.size() < want) begin
                    due_results.push_back(pack_result(0, 1'b0, 1'b1));
                end else begin
                    next_ptr = PAGE_W'(p);
                    foreach (run_pages[k]) begin
                        due_results.push_back(pack_result(run_pages[k], 1'b1,
                                                          k == run_pages.size() - 1));
                    end
                end
            end
            default: begin
                // Mark used or mark free; pages past the total are refused.
                if (req.page_index >= tot) begin
                    due_results.push_back(pack_result(0, 1'b0, 1'b1));
                end else begin
                    page_used[req.page_index] = (req.kind == K_MARK_USED);
                    due_results.push_back(pack_result(0, 1'b1, 1'b1));
                end
            end
        endcase
    endtask

    // Results are checked before a request taken at the same edge is applied.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (page_used[k]) begin
                page_used[k] = 1'b0;
            end
            next_ptr = '0;
            total_pages = TOTAL_RESET;
            due_results.delete();
        end else begin
            if (i_strobe) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result found_page %0d success %0b last %0b",
                             $time, i_res.found_page, i_res.success, i_res.last);
                    fails++;
                end else begin
                    head = due_results.pop_front();
                    if (head.found_page !== i_res.found_page) begin
                        $display("%0t: found_page expected %0d, actual %0d",
                                 $time, head.found_page, i_res.found_page);
                        fails++;
                    end
                    if (head.success !== i_res.success) begin
                        $display("%0t: success expected %0b, actual %0b",
                                 $time, head.success, i_res.success);
                        fails++;
                    end
                    if (head.last !== i_res.last) begin
                        $display("%0t: last expected %0b, actual %0b",
                                 $time, head.last, i_res.last);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                total_pages = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                search_and_mark(i_req);
            end
        end
        o_pending = due_results.size();
        o_fail_count = fails;
    end

endmodule

### tb/sv/tb_next_fit_page_bitmap_allocator_core.sv
// Testbench top: drives requests and page-count writes into the allocator and gives the verdict.
`timescale 1ns / 1ps
module tb_next_fit_page_bitmap_allocator_core
    import nfpa_pkg::*;
();

    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 300;
    localparam int BLOCK_ITEMS = 49;
    localparam int BLOCKS      = 6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_req               i_req = '0;
    logic               i_cfg_we = 1'b0;
    logic [TOTAL_W-1:0] i_cfg_wdata = '0;
    logic               o_strobe;
    t_res               o_res;

    int                 fail_count;
    int                 pending;
    int                 quiet_cycles = 0;
    int                 idle_pct = 0;
    t_kind              inflight_kind = K_MARK_USED;
    logic [PAGE_W-1:0]  found_pages [$];
    logic [TOTAL_W-1:0] cur_total = TOTAL_RESET;

    always #5 i_clk = ~i_clk;

    next_fit_page_bitmap_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

    nfpa_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_strobe    (o_strobe),
        .i_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog: ends the run after too many cycles with no request, result or write.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("next_fit_page_bitmap_allocator_core: mismatch");
                $finish;
            end
        end
    end

    // Keep pages handed out by finds so later requests can allocate them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe && o_res.success &&
            (inflight_kind == K_FIND_ONE || inflight_kind == K_FIND_RUN)) begin
            found_pages.push_back(o_res.found_page);
            if (found_pages.size() > 64) begin
                found_pages.delete(0);
            end
        end
        if (i_rst_n && start && !busy) begin
            inflight_kind = i_req.kind;
        end
    end

    function automatic t_req mk_req(input t_kind kind, input int unsigned page,
                                    input int unsigned len);
        t_req r;
        r.kind       = kind;
        r.page_index = PAGE_W'(page);
        r.run_length = RUN_W'(len);
        return r;
    endfunction

    // Mostly allocations of found pages and in-range marks, with some noise.
    function automatic t_req random_req();
        int unsigned eff;
        int unsigned roll;
        int unsigned max_len;
        t_req        r;
        eff = cur_total;
        if (eff < 1) begin
            eff = 1;
        end
        if (eff > PAGES_DEF) begin
            eff = PAGES_DEF;
        end
        max_len = (eff + 2 < MAX_RUN_DEF) ? eff + 2 : MAX_RUN_DEF;
        r.page_index = PAGE_W'($urandom_range(0, PAGES_DEF - 1));
        r.run_length = RUN_W'($urandom_range(0, 63));
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            r.kind = K_FIND_ONE;
        end else if (roll < 35) begin
            r.kind = K_FIND_RUN;
            if ($urandom_range(0, 9) != 0) begin
                r.run_length = RUN_W'($urandom_range(1, max_len));
            end
        end else if (roll < 75) begin
            r.kind = K_MARK_USED;
            if (found_pages.size() > 0 && $urandom_range(0, 1) == 1) begin
                r.page_index = found_pages.pop_front();
            end else if ($urandom_range(0, 9) != 0) begin
                r.page_index = PAGE_W'($urandom_range(0, eff - 1));
            end
        end else begin
            r.kind = K_MARK_FREE;
            if ($urandom_range(0, 9) != 0) begin
                r.page_index = PAGE_W'($urandom_range(0, eff - 1));
            end
        end
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send(input t_req req);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending until every owed result has come and the block is idle.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_total(input logic [TOTAL_W-1:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_total = value;
    endtask

    initial begin
        logic [TOTAL_W-1:0] block_total [BLOCKS];
        block_total = '{13'd40, 13'd4096, 13'd1, 13'd8191, 13'd0, 13'd2};
        block_total[4] = TOTAL_W'($urandom_range(2, 96));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full map after reset: plain finds, the longest run, bad lengths, edge pages.
        send(mk_req(K_FIND_ONE, 0, 0));
        send(mk_req(K_FIND_RUN, 0, MAX_RUN_DEF));
        send(mk_req(K_MARK_USED, 0, 0));
        send(mk_req(K_MARK_USED, PAGES_DEF - 1, 0));
        send(mk_req(K_FIND_ONE, 0, 0));
        send(mk_req(K_FIND_RUN, 0, 0));
        send(mk_req(K_FIND_RUN, 0, 63));
        send(mk_req(K_FIND_RUN, 0, MAX_RUN_DEF + 1));
        send(mk_req(K_FIND_RUN, 0, 1));
        send(mk_req(K_MARK_FREE, PAGES_DEF - 1, 0));

        // Shrink below the pointer, then fill the map to force full wraps.
        write_total(13'd3);
        send(mk_req(K_FIND_ONE, 0, 0));
        send(mk_req(K_MARK_USED, 1, 0));
        send(mk_req(K_MARK_USED, 2, 0));
        send(mk_req(K_FIND_ONE, 0, 0));
        send(mk_req(K_FIND_RUN, 0, 1));
        send(mk_req(K_MARK_USED, 3, 0));
        send(mk_req(K_MARK_FREE, 2, 0));
        send(mk_req(K_FIND_RUN, 0, 2));
        send(mk_req(K_FIND_RUN, 0, 1));

        // A zero total acts as a single page.
        write_total(13'd0);
        send(mk_req(K_FIND_ONE, 0, 0));
        send(mk_req(K_MARK_FREE, 0, 0));
        send(mk_req(K_FIND_RUN, 0, 1));
        send(mk_req(K_MARK_USED, 1, 0));

        // A total above the map size acts as the whole map.
        write_total(13'd8191);
        send(mk_req(K_FIND_ONE, 0, 0));

        // Random blocks, each with its own page count and a sender idle rate set per pair of blocks.
        for (int blk = 0; blk < BLOCKS; blk++) begin
            write_total(block_total[blk]);
            idle_pct = (blk < 2) ? 9 : ((blk < 4) ? 48 : 0);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 4) begin
                    wait_drained();
                end
                send(random_req());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("next_fit_page_bitmap_allocator_core: match");
        end else begin
            $display("next_fit_page_bitmap_allocator_core: mismatch");
        end
        $finish;
    end

endmodule

### next_fit_page_bitmap_allocator_core.f
src/nfpa_pkg.sv
src/nfpa_rem.sv
src/next_fit_page_bitmap_allocator_core.sv
tb/sv/nfpa_checker.sv
tb/sv/tb_next_fit_page_bitmap_allocator_core.sv
